[hdl/mts_pkg.sv]
`default_nettype none

package mts_pkg;

  // Stack geometry and value widths.
  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ENTRY_WIDTH = VALUE_WIDTH + 2;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int ADDR_WIDTH  = $clog2(DEPTH);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;
  typedef logic [ADDR_WIDTH-1:0]         addr_t;

  // Operation codes carried on the func input.
  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

  // Values worked out by the decode unit from the push value, the top entry and the minimum.
  typedef struct packed {
    entry_t push_entry;
    value_t push_min;
    value_t pop_min;
    value_t top_decoded;
  } update_t;

endpackage

`default_nettype wire

[hdl/mts_ram.sv]
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/mts_decode.sv]
`default_nettype none

module mts_decode (
  input  wire logic             empty,
  input  wire mts_pkg::value_t  push_value,
  input  wire mts_pkg::entry_t  top_entry,
  input  wire mts_pkg::value_t  cur_min,
  output mts_pkg::update_t      upd
);

  import mts_pkg::*;

  entry_t x_ext;
  entry_t min_ext;
  entry_t enc_entry;
  entry_t restored;
  logic   push_below;
  logic   top_encoded;

  // Widen both operands so the doubling cannot overflow.
  assign x_ext   = {{(ENTRY_WIDTH-VALUE_WIDTH){push_value[VALUE_WIDTH-1]}}, push_value};
  assign min_ext = {{(ENTRY_WIDTH-VALUE_WIDTH){cur_min[VALUE_WIDTH-1]}}, cur_min};

  // A push below the minimum stores 2*value - old minimum.
  assign push_below = push_value < cur_min;
  assign enc_entry  = (x_ext <<< 1) - min_ext;

  // An entry below the minimum is encoded; popping it restores the old minimum.
  assign top_encoded = top_entry < min_ext;
  assign restored    = (min_ext <<< 1) - top_entry;

  always_comb begin
    if (empty || !push_below) begin
      upd.push_entry = x_ext;
      upd.push_min   = empty ? push_value : cur_min;
    end else begin
      upd.push_entry = enc_entry;
      upd.push_min   = push_value;
    end
    upd.pop_min     = top_encoded ? restored[VALUE_WIDTH-1:0] : cur_min;
    upd.top_decoded = top_encoded ? cur_min : top_entry[VALUE_WIDTH-1:0];
  end

endmodule

`default_nettype wire

[hdl/min_tracking_stack.sv]
`default_nettype none

// Channel     | Signals                                              | Transaction
// ------------+------------------------------------------------------+-------------------------
// command     | start, busy, func, push_value                        | start high, busy low
// result      | done, top_value, min_value, entry_count, is_empty,   | done high for one cycle
//             | push_rejected                                        |
//
// A push, a rejected push or a pop that empties the stack or finds it empty
// reports in the cycle after acceptance. A pop that leaves entries passes
// through ST_POP_WAIT before done is registered: the new top entry comes from
// the stack memory, whose read data is registered, and busy is high meanwhile.
// Reset clears the count and the minimum; the memory needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.

module min_tracking_stack (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             func,
  input  wire mts_pkg::value_t  push_value,
  output logic                  done,
  output mts_pkg::value_t       top_value,
  output mts_pkg::value_t       min_value,
  output mts_pkg::count_t       entry_count,
  output logic                  is_empty,
  output logic                  push_rejected
);

  import mts_pkg::*;

  state_t  state;
  state_t  state_next;
  count_t  fill;
  count_t  fill_less_two;
  entry_t  top_entry;
  entry_t  rd_data;
  value_t  cur_min;
  update_t upd;
  logic    accept;
  logic    full;
  logic    empty;
  logic    push_ok;
  logic    pop_ok;
  logic    pop_reload;
  addr_t   rd_addr;

  // Transaction decode.
  assign accept        = start && !busy;
  assign empty         = fill == '0;
  assign full          = fill == COUNT_WIDTH'(DEPTH);
  assign push_ok       = accept && (func == FUNC_PUSH) && !full;
  assign pop_ok        = accept && (func == FUNC_POP) && !empty;
  assign pop_reload    = pop_ok && (fill > COUNT_WIDTH'(1));
  assign fill_less_two = fill - COUNT_WIDTH'(2);
  assign rd_addr       = fill_less_two[ADDR_WIDTH-1:0];

  mts_decode u_decode (
    .empty      (empty),
    .push_value (push_value),
    .top_entry  (top_entry),
    .cur_min    (cur_min),
    .upd        (upd)
  );

  // Every pushed entry is written at its own slot; a pop that leaves entries fetches the one below.
  mts_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (fill[ADDR_WIDTH-1:0]),
    .wdata (upd.push_entry),
    .re    (pop_reload),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Next state.
  always_comb begin
    unique case (state)
      ST_IDLE:     state_next = pop_reload ? ST_POP_WAIT : ST_IDLE;
      ST_POP_WAIT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    unique case (state)
      ST_IDLE:     busy = 1'b0;
      ST_POP_WAIT: busy = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill          <= '0;
      cur_min       <= '0;
      done          <= 1'b0;
      push_rejected <= 1'b0;
    end else begin
      state         <= state_next;
      done          <= (accept && !pop_reload) || (state == ST_POP_WAIT);
      if (accept) begin
        push_rejected <= (func == FUNC_PUSH) && full;
      end
      if (push_ok) begin
        fill    <= fill + COUNT_WIDTH'(1);
        cur_min <= upd.push_min;
      end else if (pop_ok) begin
        fill    <= fill - COUNT_WIDTH'(1);
        cur_min <= upd.pop_min;
      end
    end
  end

  // The top entry is kept in a register beside the memory.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      top_entry <= upd.push_entry;
    end else if (state == ST_POP_WAIT) begin
      top_entry <= rd_data;
    end
  end

  // Result fields follow the registered state during the strobe cycle.
  assign entry_count = fill;
  assign is_empty    = empty;
  assign top_value   = empty ? '1 : upd.top_decoded;
  assign min_value   = empty ? '1 : cur_min;

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) fill <= COUNT_WIDTH'(DEPTH))
    else $error("stack count exceeds capacity");

  // A pop waiting on the memory always reports in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (state == ST_POP_WAIT) |=> done)
    else $error("pop result missing after memory read");

  // Every push reports in the cycle after it is accepted.
  assert property (@(posedge clk) disable iff (rst)
      (accept && (func == FUNC_PUSH)) |=> (done && !busy))
    else $error("push result not reported");

  // A rejected push is reported only on a full stack.
  assert property (@(posedge clk) disable iff (rst)
      (done && push_rejected) |-> (entry_count == COUNT_WIDTH'(DEPTH)))
    else $error("push rejected while stack not full");

  // The minimum never exceeds the decoded top.
  assert property (@(posedge clk) disable iff (rst)
      (done && !is_empty) |-> (min_value <= top_value))
    else $error("minimum above top value");

endmodule

`default_nettype wire
